[design/rtnh_pkg.sv]
`timescale 1ns / 1ps
// Package: item types, sequencer codes and micro-op table of the ray/triangle nearest-hit block
package rtnh_pkg;

  localparam int DW    = 128;
  localparam int YW    = 34;
  localparam int MCW   = 6;
  localparam int DCW   = 7;
  localparam int SCW   = 5;
  localparam int MOP_W = 5;

  localparam logic CMD_RAY = 1'b0;
  localparam logic CMD_TRI = 1'b1;

  localparam logic [MOP_W-1:0] MOP_TRI_FIRST = 5'd0;
  localparam logic [MOP_W-1:0] MOP_TRI_LAST  = 5'd23;
  localparam logic [MOP_W-1:0] MOP_RAY_FIRST = 5'd24;
  localparam logic [MOP_W-1:0] MOP_RAY_LAST  = 5'd26;
  localparam logic [MOP_W-1:0] MOP_PT_FIRST  = 5'd27;

  localparam logic [30:0] DIST_MAX = 31'h7FFF_FFFF;
  localparam logic [33:0] OFF_LIM  = 34'h2_0000_0000;

  typedef struct packed {
    logic               command;
    logic signed [31:0] ax;
    logic signed [31:0] ay;
    logic signed [31:0] az;
    logic signed [31:0] bx;
    logic signed [31:0] by_coord;
    logic signed [31:0] bz;
    logic signed [31:0] cx;
    logic signed [31:0] cy;
    logic signed [31:0] cz;
    logic [23:0]        tri_color;
    logic               last_triangle;
  } in_item_t;

  typedef struct packed {
    logic [23:0]        pixel_color;
    logic               hit;
    logic signed [31:0] hit_x;
    logic signed [31:0] hit_y;
    logic signed [31:0] hit_z;
  } out_item_t;

  typedef enum logic [4:0] {
    SRC_D0, SRC_D1, SRC_D2,
    SRC_T0, SRC_T1, SRC_T2,
    SRC_E10, SRC_E11, SRC_E12,
    SRC_E20, SRC_E21, SRC_E22,
    SRC_P0, SRC_P1, SRC_P2,
    SRC_Q0, SRC_Q1, SRC_Q2,
    SRC_LN
  } src_t;

  typedef enum logic [3:0] {
    DST_NONE,
    DST_P0, DST_P1, DST_P2,
    DST_Q0, DST_Q1, DST_Q2,
    DST_DEN, DST_AN, DST_BN, DST_LN,
    DST_SUM, DST_NUM
  } dst_t;

  typedef struct packed {
    src_t xsel;
    src_t ysel;
    logic first;
    logic neg;
    dst_t dst;
  } mop_t;

  typedef struct packed {
    logic start;
    logic first;
    logic neg;
  } mul_ctl_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_GO, ST_MUL_WAIT,
    ST_SQRT_GO, ST_SQRT_WAIT,
    ST_NORM_GO, ST_NORM_WAIT,
    ST_SIGN, ST_CHECK,
    ST_LAM_GO, ST_LAM_WAIT,
    ST_PT_DIV_GO, ST_PT_DIV_WAIT,
    ST_FIN
  } seq_state_t;

  // acc = (first ? 0 : acc) +/- x*y, written to dst when dst is set
  function automatic mop_t mop_rom(input logic [MOP_W-1:0] idx);
    mop_t m;
    case (idx)
      5'd0:  m = '{SRC_D1,  SRC_E22, 1'b1, 1'b0, DST_NONE};
      5'd1:  m = '{SRC_D2,  SRC_E21, 1'b0, 1'b1, DST_P0};
      5'd2:  m = '{SRC_D2,  SRC_E20, 1'b1, 1'b0, DST_NONE};
      5'd3:  m = '{SRC_D0,  SRC_E22, 1'b0, 1'b1, DST_P1};
      5'd4:  m = '{SRC_D0,  SRC_E21, 1'b1, 1'b0, DST_NONE};
      5'd5:  m = '{SRC_D1,  SRC_E20, 1'b0, 1'b1, DST_P2};
      5'd6:  m = '{SRC_P0,  SRC_E10, 1'b1, 1'b0, DST_NONE};
      5'd7:  m = '{SRC_P1,  SRC_E11, 1'b0, 1'b0, DST_NONE};
      5'd8:  m = '{SRC_P2,  SRC_E12, 1'b0, 1'b0, DST_DEN};
      5'd9:  m = '{SRC_P0,  SRC_T0,  1'b1, 1'b0, DST_NONE};
      5'd10: m = '{SRC_P1,  SRC_T1,  1'b0, 1'b0, DST_NONE};
      5'd11: m = '{SRC_P2,  SRC_T2,  1'b0, 1'b0, DST_AN};
      5'd12: m = '{SRC_T1,  SRC_E12, 1'b1, 1'b0, DST_NONE};
      5'd13: m = '{SRC_T2,  SRC_E11, 1'b0, 1'b1, DST_Q0};
      5'd14: m = '{SRC_T2,  SRC_E10, 1'b1, 1'b0, DST_NONE};
      5'd15: m = '{SRC_T0,  SRC_E12, 1'b0, 1'b1, DST_Q1};
      5'd16: m = '{SRC_T0,  SRC_E11, 1'b1, 1'b0, DST_NONE};
      5'd17: m = '{SRC_T1,  SRC_E10, 1'b0, 1'b1, DST_Q2};
      5'd18: m = '{SRC_Q0,  SRC_D0,  1'b1, 1'b0, DST_NONE};
      5'd19: m = '{SRC_Q1,  SRC_D1,  1'b0, 1'b0, DST_NONE};
      5'd20: m = '{SRC_Q2,  SRC_D2,  1'b0, 1'b0, DST_BN};
      5'd21: m = '{SRC_Q0,  SRC_E20, 1'b1, 1'b0, DST_NONE};
      5'd22: m = '{SRC_Q1,  SRC_E21, 1'b0, 1'b0, DST_NONE};
      5'd23: m = '{SRC_Q2,  SRC_E22, 1'b0, 1'b0, DST_LN};
      5'd24: m = '{SRC_E10, SRC_E10, 1'b1, 1'b0, DST_NONE};
      5'd25: m = '{SRC_E11, SRC_E11, 1'b0, 1'b0, DST_NONE};
      5'd26: m = '{SRC_E12, SRC_E12, 1'b0, 1'b0, DST_SUM};
      5'd27: m = '{SRC_LN,  SRC_D0,  1'b1, 1'b0, DST_NUM};
      5'd28: m = '{SRC_LN,  SRC_D1,  1'b1, 1'b0, DST_NUM};
      5'd29: m = '{SRC_LN,  SRC_D2,  1'b1, 1'b0, DST_NUM};
      default: m = '{SRC_D0, SRC_D0, 1'b1, 1'b0, DST_NONE};
    endcase
    return m;
  endfunction

endpackage

[design/rtnh_mul.sv]
`timescale 1ns / 1ps
// Shift-add multiply-accumulate unit, one multiplier bit per cycle
module rtnh_mul import rtnh_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  mul_ctl_t             ctl,
  input  logic signed [DW-1:0] x,
  input  logic signed [YW-1:0] y,
  output logic signed [DW-1:0] acc,
  output logic                 done
);

  logic                 busy_r;
  logic                 done_r;
  logic [MCW-1:0]       cnt_r;
  logic signed [DW-1:0] xs_r;
  logic signed [DW-1:0] acc_r;
  logic signed [YW-1:0] ys_r;
  logic                 last;

  assign last = (cnt_r == MCW'(YW - 1));
  assign acc  = acc_r;
  assign done = done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= busy_r && !ctl.start && last;
      if (ctl.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        ys_r   <= y;
        xs_r   <= ctl.neg ? -x : x;
        if (ctl.first) begin
          acc_r <= '0;
        end
      end else if (busy_r) begin
        // sign bit of y carries negative weight
        if (ys_r[0]) begin
          acc_r <= last ? acc_r - xs_r : acc_r + xs_r;
        end
        xs_r  <= xs_r <<< 1;
        ys_r  <= ys_r >>> 1;
        cnt_r <= cnt_r + 1'b1;
        if (last) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

endmodule

[design/rtnh_div.sv]
`timescale 1ns / 1ps
// Restoring unsigned divider, one quotient bit per cycle
module rtnh_div import rtnh_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [DW-1:0] num,
  input  logic [DW-1:0] den,
  output logic [DW-1:0] quo,
  output logic          done
);

  logic          busy_r;
  logic          done_r;
  logic [DCW-1:0] cnt_r;
  logic [DW-1:0] nq_r;
  logic [DW-1:0] rem_r;
  logic [DW-1:0] den_r;
  logic [DW:0]   rem_sh;
  logic [DW:0]   rem_diff;
  logic          ge;
  logic          last;

  assign rem_sh   = {rem_r, nq_r[DW-1]};
  assign rem_diff = rem_sh - {1'b0, den_r};
  assign ge       = (rem_sh >= {1'b0, den_r});
  assign last     = (cnt_r == DCW'(DW - 1));
  assign quo      = nq_r;
  assign done     = done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= busy_r && !start && last;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        nq_r   <= num;
        den_r  <= den;
        rem_r  <= '0;
      end else if (busy_r) begin
        rem_r <= ge ? rem_diff[DW-1:0] : rem_sh[DW-1:0];
        nq_r  <= {nq_r[DW-2:0], ge};
        cnt_r <= cnt_r + 1'b1;
        if (last) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

endmodule

[design/rtnh_sqrt.sv]
`timescale 1ns / 1ps
// Digit-by-digit integer square root of a 64-bit value, one result bit per cycle
module rtnh_sqrt import rtnh_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] val,
  output logic [31:0] root,
  output logic        done
);

  logic           busy_r;
  logic           done_r;
  logic [SCW-1:0] cnt_r;
  logic [63:0]    v_r;
  logic [63:0]    res_r;
  logic [63:0]    bit_r;
  logic [63:0]    trial;
  logic           ge;
  logic           last;

  assign trial = res_r + bit_r;
  assign ge    = (v_r >= trial);
  assign last  = (cnt_r == '1);
  assign root  = res_r[31:0];
  assign done  = done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= busy_r && !start && last;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        v_r    <= val;
        res_r  <= '0;
        bit_r  <= 64'h4000_0000_0000_0000;
      end else if (busy_r) begin
        if (ge) begin
          v_r   <= v_r - trial;
          res_r <= (res_r >> 1) + bit_r;
        end else begin
          res_r <= res_r >> 1;
        end
        bit_r <= bit_r >> 2;
        cnt_r <= cnt_r + 1'b1;
        if (last) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

endmodule

[design/ray_triangle_nearest_hit_top.sv]
`timescale 1ns / 1ps
// Top level: nearest ray/triangle hit, sequencer around shared multiply, divide and root units
// One item at a time; in_ready is high only while idle. Ray item: three multiplies, the root
// and three divides (no divides for a zero direction). Triangle item: 24 multiplies when
// rejected, plus the distance divide and three multiply-divide pairs when recorded.
// A result is registered and may wait for out_ready while the next item runs.
// Synchronous active-low reset: idle, empty output, zero direction, empty record, background 0.
module ray_triangle_nearest_hit_top import rtnh_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  logic [23:0] cfg_data
);

  localparam logic signed [35:0] PT_HI = 36'sh0_7FFF_FFFF;
  localparam logic signed [35:0] PT_LO = 36'shF_8000_0000;

  seq_state_t state_r, state_nxt;
  logic [MOP_W-1:0] mop_r;
  logic [1:0]       comp_r;
  mop_t             mop;

  logic signed [31:0]   o_r [3];
  logic signed [31:0]   d_r [3];
  logic signed [YW-1:0] e1_r [3];
  logic signed [YW-1:0] e2_r [3];
  logic signed [YW-1:0] t_r [3];
  logic signed [DW-1:0] p_r [3];
  logic signed [DW-1:0] q_r [3];
  logic signed [DW-1:0] den_r, an_r, bn_r, ln_r, num_r;
  logic [31:0]          root_r;
  logic [23:0]          color_r, bg_r, near_color_r;
  logic                 last_r, any_hit_r;
  logic [30:0]          near_dist_r;
  logic signed [31:0]   near_pt_r [3];
  logic                 out_valid_r;
  out_item_t            out_data_r;
  logic                 emit;

  mul_ctl_t             mul_ctl;
  logic signed [DW-1:0] mul_x, mul_acc, y_full;
  logic signed [YW-1:0] mul_y;
  logic                 mul_done;
  logic                 div_start, div_done;
  logic [DW-1:0]        div_n, div_d, div_q;
  logic                 sq_start, sq_done;
  logic [31:0]          sq_root;

  logic signed [DW-1:0] ab_sum;
  logic                 reject, rec;
  logic [30:0]          lam_dist;
  logic signed [YW-1:0] e1_sel;
  logic [YW-1:0]        e1_mag;
  logic [DW-1:0]        num_mag;
  logic [31:0]          norm_q;
  logic [33:0]          off_mag;
  logic signed [35:0]   off_s, pt_sum;
  logic signed [31:0]   pt_sat;

  function automatic logic signed [DW-1:0] src_pick(input src_t s);
    logic signed [DW-1:0] v;
    case (s)
      SRC_D0:  v = DW'(d_r[0]);
      SRC_D1:  v = DW'(d_r[1]);
      SRC_D2:  v = DW'(d_r[2]);
      SRC_T0:  v = DW'(t_r[0]);
      SRC_T1:  v = DW'(t_r[1]);
      SRC_T2:  v = DW'(t_r[2]);
      SRC_E10: v = DW'(e1_r[0]);
      SRC_E11: v = DW'(e1_r[1]);
      SRC_E12: v = DW'(e1_r[2]);
      SRC_E20: v = DW'(e2_r[0]);
      SRC_E21: v = DW'(e2_r[1]);
      SRC_E22: v = DW'(e2_r[2]);
      SRC_P0:  v = p_r[0];
      SRC_P1:  v = p_r[1];
      SRC_P2:  v = p_r[2];
      SRC_Q0:  v = q_r[0];
      SRC_Q1:  v = q_r[1];
      SRC_Q2:  v = q_r[2];
      SRC_LN:  v = ln_r;
      default: v = '0;
    endcase
    return v;
  endfunction

  assign mop       = mop_rom(mop_r);
  assign in_ready  = (state_r == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign emit      = (state_r == ST_FIN) && last_r && (!out_valid_r || out_ready);

  always_comb begin
    mul_x  = src_pick(mop.xsel);
    y_full = src_pick(mop.ysel);
    mul_y  = y_full[YW-1:0];
  end

  // test and record decisions
  always_comb begin
    ab_sum   = an_r + bn_r;
    reject   = an_r[DW-1] || (den_r < an_r) || bn_r[DW-1] || (den_r < ab_sum) ||
               ln_r[DW-1] || (ln_r == '0);
    lam_dist = (|div_q[DW-1:31]) ? DIST_MAX : div_q[30:0];
    rec      = !any_hit_r || (lam_dist < near_dist_r);
  end

  // divider operands and result shaping
  always_comb begin
    e1_sel  = e1_r[comp_r];
    e1_mag  = e1_sel[YW-1] ? YW'(-e1_sel) : YW'(e1_sel);
    num_mag = num_r[DW-1] ? DW'(-num_r) : DW'(num_r);
    norm_q  = e1_sel[YW-1] ? -div_q[31:0] : div_q[31:0];
    off_mag = ((|div_q[DW-1:34]) || (div_q[33:0] > OFF_LIM)) ? OFF_LIM : div_q[33:0];
    off_s   = num_r[DW-1] ? -$signed({2'b00, off_mag}) : $signed({2'b00, off_mag});
    pt_sum  = 36'(o_r[comp_r]) + off_s;
    if (pt_sum > PT_HI) begin
      pt_sat = 32'sh7FFF_FFFF;
    end else if (pt_sum < PT_LO) begin
      pt_sat = 32'sh8000_0000;
    end else begin
      pt_sat = pt_sum[31:0];
    end
    case (state_r)
      ST_NORM_GO: begin
        div_n = DW'(e1_mag) << FRAC_BITS;
        div_d = DW'(root_r);
      end
      ST_PT_DIV_GO: begin
        div_n = num_mag;
        div_d = den_r;
      end
      default: begin
        div_n = ln_r << FRAC_BITS;
        div_d = den_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    mul_ctl.start = 1'b0;
    mul_ctl.first = mop.first;
    mul_ctl.neg   = mop.neg;
    div_start     = 1'b0;
    sq_start      = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_MUL_GO;
      end
      ST_MUL_GO: begin
        mul_ctl.start = 1'b1;
        state_nxt     = ST_MUL_WAIT;
      end
      ST_MUL_WAIT: begin
        if (mul_done) begin
          if (mop_r == MOP_TRI_LAST) state_nxt = ST_SIGN;
          else if (mop_r == MOP_RAY_LAST) state_nxt = ST_SQRT_GO;
          else if (mop_r >= MOP_PT_FIRST) state_nxt = ST_PT_DIV_GO;
          else state_nxt = ST_MUL_GO;
        end
      end
      ST_SQRT_GO: begin
        sq_start  = 1'b1;
        state_nxt = ST_SQRT_WAIT;
      end
      ST_SQRT_WAIT: begin
        if (sq_done) state_nxt = (sq_root == '0) ? ST_IDLE : ST_NORM_GO;
      end
      ST_NORM_GO: begin
        div_start = 1'b1;
        state_nxt = ST_NORM_WAIT;
      end
      ST_NORM_WAIT: begin
        if (div_done) state_nxt = (comp_r == 2'd2) ? ST_IDLE : ST_NORM_GO;
      end
      ST_SIGN: begin
        state_nxt = (den_r == '0) ? ST_FIN : ST_CHECK;
      end
      ST_CHECK: begin
        state_nxt = reject ? ST_FIN : ST_LAM_GO;
      end
      ST_LAM_GO: begin
        div_start = 1'b1;
        state_nxt = ST_LAM_WAIT;
      end
      ST_LAM_WAIT: begin
        if (div_done) state_nxt = rec ? ST_MUL_GO : ST_FIN;
      end
      ST_PT_DIV_GO: begin
        div_start = 1'b1;
        state_nxt = ST_PT_DIV_WAIT;
      end
      ST_PT_DIV_WAIT: begin
        if (div_done) state_nxt = (comp_r == 2'd2) ? ST_FIN : ST_MUL_GO;
      end
      ST_FIN: begin
        if (!last_r || !out_valid_r || out_ready) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bg_r        <= '0;
      any_hit_r   <= 1'b0;
      out_valid_r <= 1'b0;
      d_r[0]      <= '0;
      d_r[1]      <= '0;
      d_r[2]      <= '0;
      o_r[0]      <= '0;
      o_r[1]      <= '0;
      o_r[2]      <= '0;
    end else begin
      if (cfg_valid) bg_r <= cfg_data;
      if (out_valid_r && out_ready && !emit) out_valid_r <= 1'b0;
      case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            color_r <= in_data.tri_color;
            last_r  <= in_data.last_triangle;
            comp_r  <= '0;
            if (in_data.command == CMD_RAY) begin
              o_r[0]    <= in_data.ax;
              o_r[1]    <= in_data.ay;
              o_r[2]    <= in_data.az;
              e1_r[0]   <= YW'(in_data.bx);
              e1_r[1]   <= YW'(in_data.by_coord);
              e1_r[2]   <= YW'(in_data.bz);
              any_hit_r <= 1'b0;
              mop_r     <= MOP_RAY_FIRST;
            end else begin
              e1_r[0] <= YW'(in_data.bx) - YW'(in_data.ax);
              e1_r[1] <= YW'(in_data.by_coord) - YW'(in_data.ay);
              e1_r[2] <= YW'(in_data.bz) - YW'(in_data.az);
              e2_r[0] <= YW'(in_data.cx) - YW'(in_data.ax);
              e2_r[1] <= YW'(in_data.cy) - YW'(in_data.ay);
              e2_r[2] <= YW'(in_data.cz) - YW'(in_data.az);
              t_r[0]  <= YW'(o_r[0]) - YW'(in_data.ax);
              t_r[1]  <= YW'(o_r[1]) - YW'(in_data.ay);
              t_r[2]  <= YW'(o_r[2]) - YW'(in_data.az);
              mop_r   <= MOP_TRI_FIRST;
            end
          end
        end
        ST_MUL_WAIT: begin
          if (mul_done) begin
            case (mop.dst)
              DST_P0:  p_r[0] <= mul_acc;
              DST_P1:  p_r[1] <= mul_acc;
              DST_P2:  p_r[2] <= mul_acc;
              DST_Q0:  q_r[0] <= mul_acc;
              DST_Q1:  q_r[1] <= mul_acc;
              DST_Q2:  q_r[2] <= mul_acc;
              DST_DEN: den_r  <= mul_acc;
              DST_AN:  an_r   <= mul_acc;
              DST_BN:  bn_r   <= mul_acc;
              DST_LN:  ln_r   <= mul_acc;
              DST_SUM: num_r  <= mul_acc;
              DST_NUM: num_r  <= mul_acc;
              default: ;
            endcase
            if (mop_r != MOP_TRI_LAST && mop_r != MOP_RAY_LAST && mop_r < MOP_PT_FIRST) begin
              mop_r <= mop_r + 1'b1;
            end
          end
        end
        ST_SQRT_WAIT: begin
          if (sq_done) begin
            root_r <= sq_root;
            if (sq_root == '0) begin
              d_r[0] <= '0;
              d_r[1] <= '0;
              d_r[2] <= '0;
            end
          end
        end
        ST_NORM_WAIT: begin
          if (div_done) begin
            d_r[comp_r] <= norm_q;
            comp_r      <= comp_r + 2'd1;
          end
        end
        ST_SIGN: begin
          if (den_r[DW-1]) begin
            den_r <= -den_r;
            an_r  <= -an_r;
            bn_r  <= -bn_r;
            ln_r  <= -ln_r;
          end
        end
        ST_LAM_WAIT: begin
          if (div_done && rec) begin
            any_hit_r    <= 1'b1;
            near_dist_r  <= lam_dist;
            near_color_r <= color_r;
            comp_r       <= '0;
            mop_r        <= MOP_PT_FIRST;
          end
        end
        ST_PT_DIV_WAIT: begin
          if (div_done) begin
            near_pt_r[comp_r] <= pt_sat;
            comp_r            <= comp_r + 2'd1;
            mop_r             <= mop_r + 1'b1;
          end
        end
        ST_FIN: begin
          if (emit) begin
            out_valid_r             <= 1'b1;
            out_data_r.pixel_color  <= any_hit_r ? near_color_r : bg_r;
            out_data_r.hit          <= any_hit_r;
            out_data_r.hit_x        <= any_hit_r ? near_pt_r[0] : '0;
            out_data_r.hit_y        <= any_hit_r ? near_pt_r[1] : '0;
            out_data_r.hit_z        <= any_hit_r ? near_pt_r[2] : '0;
            any_hit_r               <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  rtnh_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (mul_ctl),
    .x     (mul_x),
    .y     (mul_y),
    .acc   (mul_acc),
    .done  (mul_done)
  );

  rtnh_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_n),
    .den   (div_d),
    .quo   (div_q),
    .done  (div_done)
  );

  rtnh_sqrt u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sq_start),
    .val   (num_r[63:0]),
    .root  (sq_root),
    .done  (sq_done)
  );

endmodule

[design/rtnh_chk.sv]
`timescale 1ns / 1ps
// Port-level checker for the nearest-hit block, bound to the top level
module rtnh_chk import rtnh_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result item changed while stalled");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.hit |-> out_data.hit_x == 0 && out_data.hit_y == 0 &&
                                   out_data.hit_z == 0)
    else $error("miss carries a nonzero point");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("ready right after an accepted item");

  a_out_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared without a busy sequencer");

endmodule

bind ray_triangle_nearest_hit_top rtnh_chk u_chk (.*);

[tb/sv/tb_ray_triangle_nearest_hit_top.sv]
`timescale 1ns / 1ps
// Testbench: directed plan and random ray/triangle streams against a fixed-point nearest-hit model
module tb_ray_triangle_nearest_hit_top;
  import rtnh_pkg::*;

  typedef logic signed [127:0] wide_t;

  localparam int    UNIT      = 65536;
  localparam int    WATCH_MAX = 40000;
  localparam int    SETTLE    = 2500;
  localparam int    HOLD_LEN  = 6000;
  localparam wide_t OFF_MAX   = 128'sd8589934592;
  localparam wide_t DIST_TOP  = 128'sd2147483647;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  in_item_t    in_data;
  logic        out_valid;
  logic        out_ready;
  out_item_t   out_data;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [23:0] cfg_data;

  ray_triangle_nearest_hit_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  typedef struct {
    in_item_t  it;
    bit        typed;
    out_item_t want;
  } plan_row_t;

  // model state
  longint      ray_o [3];
  longint      ray_u [3];
  longint      near_dist;
  logic [23:0] near_col;
  longint      near_pt [3];
  bit          any_hit;
  logic [23:0] bg_color;

  out_item_t   pixels_due [$];
  int          errors;
  int          items_sent;
  int          pixels_seen;
  int          hits_seen;
  int          idle_cycles;
  bit          hold_req;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res;
    longint unsigned b4;
    res = 0;
    b4 = 64'd1 << 62;
    while (b4 > v) b4 >>= 2;
    while (b4 != 0) begin
      if (v >= res + b4) begin
        v -= res + b4;
        res = (res >> 1) + b4;
      end else begin
        res >>= 1;
      end
      b4 >>= 2;
    end
    return res;
  endfunction

  function automatic wide_t dot3(wide_t x0, wide_t x1, wide_t x2, wide_t y0, wide_t y1, wide_t y2);
    return x0 * y0 + x1 * y1 + x2 * y2;
  endfunction

  function automatic void clear_nearest();
    near_dist = 64'sh7FFF_FFFF;
    near_col = '0;
    for (int i = 0; i < 3; i++) near_pt[i] = 0;
    any_hit = 1'b0;
  endfunction

  function automatic void load_ray(in_item_t it);
    longint d [3];
    longint unsigned sum;
    longint unsigned mag;
    longint unsigned n;
    d[0] = it.bx;
    d[1] = it.by_coord;
    d[2] = it.bz;
    ray_o[0] = it.ax;
    ray_o[1] = it.ay;
    ray_o[2] = it.az;
    sum = 0;
    for (int i = 0; i < 3; i++) begin
      mag = d[i] < 0 ? -d[i] : d[i];
      sum += mag * mag;
    end
    n = int_sqrt(sum);
    for (int i = 0; i < 3; i++)
      ray_u[i] = (n == 0) ? 0 : (d[i] * UNIT) / longint'(n);
    clear_nearest();
  endfunction

  function automatic void test_tri(in_item_t it);
    longint a [3], b [3], c [3];
    wide_t dv [3], e1 [3], e2 [3], tv [3], p [3], q [3];
    wide_t den, an, bn, ln, lam, off;
    longint lam_fx, s;
    a[0] = it.ax; a[1] = it.ay; a[2] = it.az;
    b[0] = it.bx; b[1] = it.by_coord; b[2] = it.bz;
    c[0] = it.cx; c[1] = it.cy; c[2] = it.cz;
    for (int i = 0; i < 3; i++) begin
      dv[i] = ray_u[i];
      e1[i] = b[i] - a[i];
      e2[i] = c[i] - a[i];
      tv[i] = ray_o[i] - a[i];
    end
    p[0] = dv[1] * e2[2] - dv[2] * e2[1];
    p[1] = dv[2] * e2[0] - dv[0] * e2[2];
    p[2] = dv[0] * e2[1] - dv[1] * e2[0];
    den = dot3(p[0], p[1], p[2], e1[0], e1[1], e1[2]);
    if (den == 0) return;
    an = dot3(p[0], p[1], p[2], tv[0], tv[1], tv[2]);
    q[0] = tv[1] * e1[2] - tv[2] * e1[1];
    q[1] = tv[2] * e1[0] - tv[0] * e1[2];
    q[2] = tv[0] * e1[1] - tv[1] * e1[0];
    bn = dot3(q[0], q[1], q[2], dv[0], dv[1], dv[2]);
    ln = dot3(q[0], q[1], q[2], e2[0], e2[1], e2[2]);
    if (den < 0) begin
      den = -den;
      an = -an;
      bn = -bn;
      ln = -ln;
    end
    if (an < 0 || an > den) return;
    if (bn < 0 || an + bn > den) return;
    if (ln <= 0) return;
    lam = (ln * UNIT) / den;
    lam_fx = (lam > DIST_TOP) ? 64'sh7FFF_FFFF : longint'(lam);
    if (any_hit && !(lam_fx < near_dist)) return;
    any_hit = 1'b1;
    near_dist = lam_fx;
    near_col = it.tri_color;
    for (int i = 0; i < 3; i++) begin
      off = (ln * dv[i]) / den;
      if (off > OFF_MAX) off = OFF_MAX;
      if (off < -OFF_MAX) off = -OFF_MAX;
      s = ray_o[i] + longint'(off);
      if (s > 64'sh7FFF_FFFF) s = 64'sh7FFF_FFFF;
      if (s < -64'sh8000_0000) s = -64'sh8000_0000;
      near_pt[i] = s;
    end
  endfunction

  // advances the model by one item; reports the pixel it emits, if any
  function automatic bit trace_item(in_item_t it, output out_item_t px);
    px = '0;
    if (it.command == CMD_RAY) begin
      load_ray(it);
      return 1'b0;
    end
    test_tri(it);
    if (!it.last_triangle) return 1'b0;
    px.pixel_color = any_hit ? near_col : bg_color;
    px.hit = any_hit;
    px.hit_x = any_hit ? near_pt[0][31:0] : '0;
    px.hit_y = any_hit ? near_pt[1][31:0] : '0;
    px.hit_z = any_hit ? near_pt[2][31:0] : '0;
    clear_nearest();
    return 1'b1;
  endfunction

  function automatic in_item_t mk_item(logic cmd, int a0, int a1, int a2, int b0, int b1, int b2,
                                       int c0, int c1, int c2, logic [23:0] col, logic last);
    in_item_t it;
    it.command = cmd;
    it.ax = a0; it.ay = a1; it.az = a2;
    it.bx = b0; it.by_coord = b1; it.bz = b2;
    it.cx = c0; it.cy = c1; it.cz = c2;
    it.tri_color = col;
    it.last_triangle = last;
    return it;
  endfunction

  function automatic int rnd_span(int span);
    return $signed($urandom_range(0, 2 * span)) - span;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 90) return $urandom_range(1, 4);
    return $urandom_range(20, 400);
  endfunction

  task automatic send_item(in_item_t it, bit typed, out_item_t want);
    int gap;
    bit rdy;
    out_item_t px;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do begin
      @(negedge clk);
      rdy = in_ready;
      @(posedge clk);
    end while (!rdy);
    items_sent++;
    if (trace_item(it, px)) pixels_due.push_back(typed ? want : px);
  endtask

  task automatic set_background(logic [23:0] v);
    bit rdy;
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do begin
      @(negedge clk);
      rdy = cfg_ready;
      @(posedge clk);
    end while (!rdy);
    bg_color = v;
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pixels_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic run_random(int count);
    in_item_t it;
    out_item_t none;
    int ox, oy, oz, dx, dy, dz, cxv, cyv, czv, s, rad, ntri;
    none = '0;
    while (count > 0) begin
      if ($urandom_range(0, 99) < 15) begin
        it = mk_item($urandom_range(0, 1), $urandom, $urandom, $urandom, $urandom, $urandom,
                     $urandom, $urandom, $urandom, $urandom, $urandom, $urandom_range(0, 1));
        send_item(it, 1'b0, none);
        count--;
      end else begin
        ox = rnd_span(16 * UNIT);
        oy = rnd_span(16 * UNIT);
        oz = rnd_span(16 * UNIT);
        dx = rnd_span(4 * UNIT);
        dy = rnd_span(4 * UNIT);
        dz = rnd_span(4 * UNIT);
        send_item(mk_item(CMD_RAY, ox, oy, oz, dx, dy, dz, $urandom, $urandom, $urandom,
                          $urandom, $urandom_range(0, 1)), 1'b0, none);
        count--;
        ntri = $urandom_range(1, 4);
        for (int k = 0; k < ntri; k++) begin
          s = $signed($urandom_range(0, 8)) - 2;
          cxv = ox + s * dx;
          cyv = oy + s * dy;
          czv = oz + s * dz;
          rad = $urandom_range(1, 8) * UNIT;
          it = mk_item(CMD_TRI,
                       cxv + rnd_span(rad), cyv + rnd_span(rad), czv + rnd_span(rad),
                       cxv + rnd_span(rad), cyv + rnd_span(rad), czv + rnd_span(rad),
                       cxv + rnd_span(rad), cyv + rnd_span(rad), czv + rnd_span(rad),
                       $urandom, (k == ntri - 1) || ($urandom_range(0, 9) == 0));
          send_item(it, 1'b0, none);
          count--;
        end
      end
    end
  endtask

  // receiver: random back-pressure, plus one long hold-off on request
  initial begin
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_LEN) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4, 5: begin
            out_ready <= 1'b1;
            repeat ($urandom_range(0, 20)) @(posedge clk);
          end
          6, 7, 8: begin
            out_ready <= 1'b0;
            repeat ($urandom_range(0, 4)) @(posedge clk);
          end
          default: begin
            out_ready <= 1'b0;
            repeat ($urandom_range(20, 300)) @(posedge clk);
          end
        endcase
      end
    end
  end

  // result checker and stall watchdog
  initial begin
    out_item_t got, want;
    forever begin
      @(negedge clk);
      if (rst_n && ((in_valid && in_ready) || (out_valid && out_ready) ||
                    (cfg_valid && cfg_ready)))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WATCH_MAX) begin
        $display("%0t: no item moved for %0d cycles", $realtime, WATCH_MAX);
        $display("end of test: mismatches");
        $finish;
      end
      if (rst_n && out_valid && out_ready) begin
        got = out_data;
        pixels_seen++;
        if (got.hit) hits_seen++;
        if (pixels_due.size() == 0) begin
          errors++;
          $display("%0t: unexpected pixel %h", $realtime, got);
        end else begin
          want = pixels_due.pop_front();
          if (got.pixel_color !== want.pixel_color) begin
            errors++;
            $display("%0t: pixel_color exp %h got %h", $realtime, want.pixel_color,
                     got.pixel_color);
          end
          if (got.hit !== want.hit) begin
            errors++;
            $display("%0t: hit exp %b got %b", $realtime, want.hit, got.hit);
          end
          if (got.hit_x !== want.hit_x) begin
            errors++;
            $display("%0t: hit_x exp %h got %h", $realtime, want.hit_x, got.hit_x);
          end
          if (got.hit_y !== want.hit_y) begin
            errors++;
            $display("%0t: hit_y exp %h got %h", $realtime, want.hit_y, got.hit_y);
          end
          if (got.hit_z !== want.hit_z) begin
            errors++;
            $display("%0t: hit_z exp %h got %h", $realtime, want.hit_z, got.hit_z);
          end
        end
      end
    end
  end

  initial begin
    plan_row_t plan [$];
    plan_row_t row;
    out_item_t blank;
    logic [23:0] bgs [5];
    int u;
    u = UNIT;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    errors = 0;
    items_sent = 0;
    pixels_seen = 0;
    hits_seen = 0;
    idle_cycles = 0;
    hold_req = 1'b0;
    bg_color = '0;
    for (int i = 0; i < 3; i++) begin
      ray_o[i] = 0;
      ray_u[i] = 0;
    end
    clear_nearest();
    blank = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // triangle before any ray, then zero direction: both miss, background at reset
    row.typed = 1'b1; row.want = blank;
    row.it = mk_item(CMD_TRI, -u, -u, 0, 3*u, -u, 0, -u, 3*u, 0, 24'hABCDEF, 1'b1);
    plan.push_back(row);
    row.typed = 1'b0;
    row.it = mk_item(CMD_RAY, 0, 0, -5*u, 0, 0, 0, 0, 0, 0, 24'h0, 1'b1);
    plan.push_back(row);
    row.typed = 1'b1;
    row.it = mk_item(CMD_TRI, -u, -u, 0, 3*u, -u, 0, -u, 3*u, 0, 24'h123456, 1'b1);
    plan.push_back(row);
    row.typed = 1'b0;
    // nearer hit replaces, tie keeps earlier, behind and parallel rejected
    row.it = mk_item(CMD_RAY, 0, 0, -5*u, 0, 0, u, 0, 0, 0, 24'h0, 1'b0);
    plan.push_back(row);
    row.it = mk_item(CMD_TRI, -u, -u, 0, 3*u, -u, 0, -u, 3*u, 0, 24'h111111, 1'b0);
    plan.push_back(row);
    row.it = mk_item(CMD_TRI, -u, -u, -2*u, 3*u, -u, -2*u, -u, 3*u, -2*u, 24'h222222, 1'b0);
    plan.push_back(row);
    row.it = mk_item(CMD_TRI, -u, -u, -2*u, 3*u, -u, -2*u, -u, 3*u, -2*u, 24'h333333, 1'b0);
    plan.push_back(row);
    row.it = mk_item(CMD_TRI, -u, -u, -9*u, 3*u, -u, -9*u, -u, 3*u, -9*u, 24'h444444, 1'b0);
    plan.push_back(row);
    row.it = mk_item(CMD_TRI, 0, -u, 0, 0, u, 0, 0, 0, u, 24'h555555, 1'b1);
    plan.push_back(row);
    // record cleared after a pixel: same ray starts afresh
    row.it = mk_item(CMD_TRI, -u, -u, 0, 3*u, -u, 0, -u, 3*u, 0, 24'hFFFFFF, 1'b1);
    plan.push_back(row);
    // extremes of the fields
    row.it = mk_item(CMD_RAY, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                     32'h8000_0000, 32'h8000_0000, 0, 0, 0, 24'hFFFFFF, 1'b0);
    plan.push_back(row);
    row.it = mk_item(CMD_TRI, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                     32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                     32'h7FFF_FFFF, 24'hFFFFFF, 1'b1);
    plan.push_back(row);
    row.it = mk_item(CMD_TRI, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
                     32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                     32'h8000_0000, 24'h000000, 1'b1);
    plan.push_back(row);
    // edge of the triangle, then alpha out of range
    row.it = mk_item(CMD_RAY, 0, 0, 0, u, 0, 0, 0, 0, 0, 24'h0, 1'b0);
    plan.push_back(row);
    row.it = mk_item(CMD_TRI, 3*u, 0, -u, 3*u, 3*u, -u, 3*u, 0, 3*u, 24'h0F0F0F, 1'b0);
    plan.push_back(row);
    row.it = mk_item(CMD_TRI, 3*u, 5*u, -u, 3*u, 8*u, -u, 3*u, 5*u, 3*u, 24'hF0F0F0, 1'b1);
    plan.push_back(row);
    row.it = mk_item(CMD_RAY, u, u, u, u, 2*u, -3*u, 0, 0, 0, 24'h0, 1'b1);
    plan.push_back(row);
    row.it = mk_item(CMD_TRI, 32'h8000_0000, 0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                     32'h8000_0000, 0, 32'h7FFF_FFFF, 32'h8000_0000, 24'hC3C3C3, 1'b1);
    plan.push_back(row);

    foreach (plan[i]) send_item(plan[i].it, plan[i].typed, plan[i].want);

    bgs[0] = 24'hFFFFFF;
    bgs[1] = 24'h000000;
    bgs[2] = $urandom;
    bgs[3] = 24'h800001;
    bgs[4] = $urandom;
    for (int ph = 0; ph < 5; ph++) begin
      drain();
      set_background(bgs[ph]);
      if (ph == 2) hold_req = 1'b1;
      run_random(126);
    end
    drain();

    $display("%0d items sent, %0d pixels checked, %0d of them hits", items_sent,
             pixels_seen, hits_seen);
    $display("covered: zero and extreme rays, ties, edges, long output stall, five backgrounds");
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

[ray_triangle_nearest_hit_top.f]
design/rtnh_pkg.sv
design/rtnh_mul.sv
design/rtnh_div.sv
design/rtnh_sqrt.sv
design/ray_triangle_nearest_hit_top.sv
design/rtnh_chk.sv
tb/sv/tb_ray_triangle_nearest_hit_top.sv
